[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[design/ramr_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Widths, command codes and controller interface types.
// ----------------------------------------------------------------------------
package ramr_pkg;
    localparam int OPERAND_BITS = 16;
    localparam int MAG_BITS     = 2 * OPERAND_BITS + 1;
    localparam int NUM_BITS     = 33;
    localparam int DEN_BITS     = 31;
    localparam int CNT_BITS     = $clog2(MAG_BITS + 1);

    localparam logic [1:0] CMD_MAKE = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_MUL  = 2'd2;

    typedef struct packed {
        logic load;
        logic prod;
        logic form;
        logic mod_start;
        logic mod_step;
        logic mod_done;
        logic swap;
        logic divn_start;
        logic divd_start;
        logic div_done_n;
        logic div_done_d;
    } ramr_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic rem_zero;
        logic last_step;
    } ramr_stat_t;
endpackage

[design/ramr_datapath.sv]
// ----------------------------------------------------------------------------
// Rational datapath
// Products, magnitudes, shared restoring divider for Euclid and quotients.
// ----------------------------------------------------------------------------
module ramr_datapath import ramr_pkg::*;
(
    input  logic                           clk,
    input  logic [1:0]                     cmd,
    input  logic signed [OPERAND_BITS-1:0] a_num,
    input  logic signed [OPERAND_BITS-1:0] a_den,
    input  logic signed [OPERAND_BITS-1:0] b_num,
    input  logic signed [OPERAND_BITS-1:0] b_den,
    input  ramr_cmd_t                      ctl,
    output ramr_stat_t                     stat,
    output logic [NUM_BITS-1:0]            res_num,
    output logic [DEN_BITS-1:0]            res_den
);
    localparam int PB = 2 * OPERAND_BITS;

    logic [1:0]                     cmd_reg;
    logic signed [OPERAND_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PB-1:0]           p0_reg, p1_reg, p2_reg;
    logic signed [MAG_BITS-1:0]     num_s, den_s;
    logic [MAG_BITS-1:0]            mn_reg, md_reg, q_reg, p_reg, g_reg;
    logic                           neg_reg;
    logic [MAG_BITS-1:0]            dvd_reg, quo_reg, rem_reg, dvs_reg;
    logic [CNT_BITS-1:0]            cnt_reg;
    logic [MAG_BITS:0]              trial;
    logic [MAG_BITS-1:0]            qn_reg;
    logic [NUM_BITS-1:0]            rn_reg;
    logic [DEN_BITS-1:0]            rd_reg;

    assign trial = {rem_reg, dvd_reg[MAG_BITS-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD:
            begin
                num_s = MAG_BITS'(p0_reg) + MAG_BITS'(p1_reg);
                den_s = MAG_BITS'(p2_reg);
            end
            CMD_MUL:
            begin
                num_s = MAG_BITS'(p0_reg);
                den_s = MAG_BITS'(p2_reg);
            end
            default:
            begin
                num_s = MAG_BITS'(an_reg);
                den_s = MAG_BITS'(ad_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        if (ctl.prod)
        begin
            p0_reg <= an_reg * (cmd_reg == CMD_MUL ? bn_reg : bd_reg);
            p1_reg <= bn_reg * ad_reg;
            p2_reg <= ad_reg * bd_reg;
        end
        if (ctl.form)
        begin
            neg_reg <= num_s[MAG_BITS-1] ^ den_s[MAG_BITS-1];
            mn_reg  <= num_s[MAG_BITS-1] ? -num_s : num_s;
            md_reg  <= den_s[MAG_BITS-1] ? -den_s : den_s;
            q_reg   <= num_s[MAG_BITS-1] ? -num_s : num_s;
            p_reg   <= den_s[MAG_BITS-1] ? -den_s : den_s;
        end
        if (ctl.swap)
        begin
            q_reg <= p_reg;
            p_reg <= rem_reg;
        end
        if (ctl.mod_start)
        begin
            dvd_reg <= q_reg;
            dvs_reg <= p_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.divn_start || ctl.divd_start)
        begin
            dvd_reg <= ctl.divn_start ? mn_reg : md_reg;
            dvs_reg <= g_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.mod_step)
        begin
            dvd_reg <= dvd_reg << 1;
            if (!trial[MAG_BITS])
            begin
                rem_reg <= trial[MAG_BITS-1:0];
                quo_reg <= {quo_reg[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[MAG_BITS-2:0], dvd_reg[MAG_BITS-1]};
                quo_reg <= {quo_reg[MAG_BITS-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ctl.mod_done)
            g_reg <= p_reg;
        if (ctl.div_done_n)
            qn_reg <= quo_reg;
        if (ctl.div_done_d)
        begin
            rn_reg <= neg_reg ? NUM_BITS'(-qn_reg) : NUM_BITS'(qn_reg);
            rd_reg <= DEN_BITS'(quo_reg);
        end
    end

    assign stat.den_zero  = (md_reg == '0);
    assign stat.num_zero  = (mn_reg == '0);
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.last_step = (cnt_reg == CNT_BITS'(MAG_BITS - 1));
    assign res_num = rn_reg;
    assign res_den = rd_reg;
endmodule

[design/ramr_ctrl.sv]
// ----------------------------------------------------------------------------
// Rational controller
// Sequences load, products, Euclid loop and the two quotient divisions.
// ----------------------------------------------------------------------------
module ramr_ctrl import ramr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_fire,
    input  ramr_stat_t stat,
    output ramr_cmd_t  ctl,
    output logic       busy,
    output logic       out_valid,
    output logic       res_sel_err,
    output logic       res_sel_zero
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_FORM  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_MOD   = 4'd4;
    localparam logic [3:0] S_MODCK = 4'd5;
    localparam logic [3:0] S_DIVN  = 4'd6;
    localparam logic [3:0] S_DIVD  = 4'd7;
    localparam logic [3:0] S_DIVQ  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       err_reg, err_next, zero_reg, zero_next;
    logic       second_reg, second_next;

    always_comb
    begin
        ctl         = '0;
        state_next  = state_reg;
        err_next    = err_reg;
        zero_next   = zero_reg;
        second_next = second_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_PROD;
                end
            S_PROD:
            begin
                ctl.prod   = 1'b1;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                ctl.form   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                err_next  = stat.den_zero;
                zero_next = stat.num_zero;
                if (stat.den_zero || stat.num_zero)
                    state_next = S_OUT;
                else
                begin
                    ctl.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (stat.last_step)
                    state_next = S_MODCK;
            end
            S_MODCK:
                if (stat.rem_zero)
                begin
                    ctl.mod_done = 1'b1;
                    second_next  = 1'b0;
                    state_next   = S_DIVN;
                end
                else
                begin
                    ctl.swap   = 1'b1;
                    state_next = S_CHECK;
                end
            S_DIVN:
            begin
                if (second_reg)
                    ctl.divd_start = 1'b1;
                else
                    ctl.divn_start = 1'b1;
                state_next = S_DIVD;
            end
            S_DIVD:
            begin
                ctl.mod_step = 1'b1;
                if (stat.last_step)
                    state_next = S_DIVQ;
            end
            // quotient complete only after the last step has been clocked
            S_DIVQ:
                if (!second_reg)
                begin
                    ctl.div_done_n = 1'b1;
                    second_next    = 1'b1;
                    state_next     = S_DIVN;
                end
                else
                begin
                    ctl.div_done_d = 1'b1;
                    state_next     = S_OUT;
                end
            S_OUT:
                if (out_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            err_reg    <= 1'b0;
            zero_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            err_reg    <= err_next;
            zero_reg   <= zero_next;
            second_reg <= second_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign res_sel_err  = err_reg;
    assign res_sel_zero = zero_reg;
endmodule

[design/rational_add_mul_reduce_core.sv]
// ----------------------------------------------------------------------------
// Rational add / multiply / reduce core
// Forms a fraction, sum or product and reduces it to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* takes one item: cmd, a_num, a_den, b_num, b_den.
//   m_axis_* delivers one result item: res_num, res_den, error.
//   One item in flight; s_axis_tready is high only while the core is idle.
//   Sequence: products and magnitudes are registered first; each Euclid
//   remainder step runs a check, 33 divider steps and a remainder test;
//   then come the two quotient divisions by the gcd. All use one shared
//   33-bit restoring divider, one quotient bit a cycle.
//   A zero numerator or denominator skips the divider.
//   The result holds on m_axis_tdata while m_axis_tready is low; no new
//   item is taken until it is delivered.
//   Reset empties the core; no result is pending afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rational_add_mul_reduce_core import ramr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50], pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_num[32:0], res_den[63:33]
    output logic [63:0] m_axis_tdata,
    // error
    output logic        m_axis_tuser
);
    ramr_cmd_t           ctl;
    ramr_stat_t          stat;
    logic                busy, sel_err, sel_zero, in_fire, out_fire;
    logic [NUM_BITS-1:0] rn;
    logic [DEN_BITS-1:0] rd;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ramr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .out_fire     (out_fire),
        .stat         (stat),
        .ctl          (ctl),
        .busy         (busy),
        .out_valid    (m_axis_tvalid),
        .res_sel_err  (sel_err),
        .res_sel_zero (sel_zero)
    );

    ramr_datapath u_dp
    (
        .clk     (clk),
        .cmd     (s_axis_tdata[1:0]),
        .a_num   (s_axis_tdata[17:2]),
        .a_den   (s_axis_tdata[33:18]),
        .b_num   (s_axis_tdata[49:34]),
        .b_den   (s_axis_tdata[65:50]),
        .ctl     (ctl),
        .stat    (stat),
        .res_num (rn),
        .res_den (rd)
    );

    always_comb
    begin
        if (sel_err)
            m_axis_tdata = '0;
        else if (sel_zero)
            m_axis_tdata = {31'd1, 33'd0};
        else
            m_axis_tdata = {rd, rn};
    end
    assign m_axis_tuser = sel_err;

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, busy && !m_axis_tvalid)
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0)
    `ASSERT_IMPLIES(a_den_pos, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:33] != 31'd0)
endmodule

[bench/rational_add_mul_reduce_core_tb.sv]
// ----------------------------------------------------------------------------
// Rational add / multiply / reduce core testbench
// Drives make, add and multiply items with directed edge cases and random
// fractions, predicts each reduced result and compares it field by field.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce_core_tb;
    import ramr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
        logic                err;
    } reduced_t;

    class fraction_scoreboard;
        reduced_t pending[$];
        int       errors;

        function longint unsigned gcd(longint unsigned q, longint unsigned p);
            longint unsigned r;
            r = q % p;
            while (r != 0)
            begin
                q = p;
                p = r;
                r = q % p;
            end
            return p;
        endfunction

        function void note_item(logic [1:0] cmd, logic signed [15:0] an,
                                logic signed [15:0] ad, logic signed [15:0] bn,
                                logic signed [15:0] bd);
            longint num;
            longint den;
            longint unsigned mn;
            longint unsigned md;
            longint unsigned g;
            longint qn;
            reduced_t f;
            if (cmd == CMD_ADD)
            begin
                num = longint'(an) * bd + longint'(bn) * ad;
                den = longint'(ad) * bd;
            end
            else if (cmd == CMD_MUL)
            begin
                num = longint'(an) * bn;
                den = longint'(ad) * bd;
            end
            else
            begin
                num = an;
                den = ad;
            end
            f = '0;
            if (den == 0)
                f.err = 1'b1;
            else if (num == 0)
                f.den = DEN_BITS'(1);
            else
            begin
                mn = num < 0 ? -num : num;
                md = den < 0 ? -den : den;
                g = gcd(mn, md);
                qn = longint'(mn / g);
                if ((num < 0) != (den < 0))
                    qn = -qn;
                f.num = qn[NUM_BITS-1:0];
                f.den = DEN_BITS'(md / g);
            end
            pending.push_back(f);
        endfunction

        function void check_result(reduced_t got);
            reduced_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.num !== want.num)
            begin
                $display("%0t: res_num expected %h actual %h", $time, want.num, got.num);
                errors++;
            end
            if (got.den !== want.den)
            begin
                $display("%0t: res_den expected %h actual %h", $time, want.den, got.den);
                errors++;
            end
            if (got.err !== want.err)
            begin
                $display("%0t: error expected %b actual %b", $time, want.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    fraction_scoreboard sb = new();
    int idle_cycles = 0;
    localparam int WATCHDOG = 20000;

    rational_add_mul_reduce_core dut (.*);

    always #10 clk = ~clk;

    // item accepted on rising edge; send holds until then
    task automatic send(logic [1:0] cmd, logic [15:0] an, logic [15:0] ad,
                        logic [15:0] bn, logic [15:0] bd);
        s_axis_tdata  <= {6'd0, bd, bn, ad, an, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(cmd, an, ad, bn, bd);
        @(negedge clk);
    endtask

    task automatic gap();
        int len;
        len = $urandom_range(0, 3);
        if (len != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (len) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 20)) - 10);
            3: return 16'($urandom_range(0, 2)) << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tdata[32:0], m_axis_tdata[63:33], m_axis_tuser});
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("** rational_add_mul_reduce_core: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern with stall-free stretches
    always @(negedge clk)
    begin
        if (($time / 20000) % 4 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        int n;
        int burst;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send(CMD_MAKE, 16'd6, 16'hfff7, 16'd0, 16'd0);
        send(CMD_MAKE, 16'd0, 16'd5, 16'd1, 16'd1);
        send(CMD_MAKE, 16'd3, 16'd0, 16'd1, 16'd1);
        send(CMD_MAKE, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
        send(CMD_MAKE, 16'h7fff, 16'h8000, 16'd0, 16'd0);
        send(2'd3, 16'hfffc, 16'd6, 16'h1234, 16'h5678);
        send(2'd3, 16'd1, 16'd0, 16'd0, 16'd0);
        send(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send(CMD_ADD, 16'd1, 16'd2, 16'hffff, 16'd2);
        send(CMD_ADD, 16'd1, 16'd0, 16'd1, 16'd3);
        send(CMD_ADD, 16'd1, 16'd3, 16'd1, 16'd0);
        send(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(CMD_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send(CMD_ADD, 16'h7fff, 16'h8001, 16'h7fff, 16'h7fff);
        send(CMD_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(CMD_MUL, 16'd0, 16'd7, 16'd5, 16'hfffd);
        send(CMD_MUL, 16'd2, 16'd0, 16'd3, 16'd4);
        send(CMD_MUL, 16'hfffe, 16'd3, 16'd3, 16'hfffe);
        send(CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        n = 0;
        while (n < 1530)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send(2'($urandom_range(0, 3)), rnd_val(), rnd_val(), rnd_val(), rnd_val());
                n++;
            end
            gap();
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.errors == 0)
            $display("** rational_add_mul_reduce_core: PASSED **");
        else
            $display("** rational_add_mul_reduce_core: FAILED **");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/ramr_pkg.sv
design/ramr_datapath.sv
design/ramr_ctrl.sv
design/rational_add_mul_reduce_core.sv
bench/rational_add_mul_reduce_core_tb.sv
